FILE: rtl/prht_pkg.sv
// Shared types and constants for the priority rectangle hit table.
// Used by prht_ctrl, prht_dp and priority_rect_hit_table_unit.
// No dependencies.
package prht_pkg;

    localparam int MAX_ENTRIES_DEF = 256;

    localparam int S_DATA_W = 184;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;
    localparam int IDX_W    = 8;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_HIT   = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // input word, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic signed [15:0] py;
        logic signed [15:0] px;
        logic               excl;
        logic signed [31:0] pri;
        logic [31:0]        tag;
        logic [7:0]         dis;
        logic signed [15:0] bottom;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] left;
        logic [7:0]         idx;
    } t_item;

    // one table entry as held in the RAM
    typedef struct packed {
        logic               excl;
        logic [7:0]         dis;
        logic [31:0]        tag;
        logic signed [31:0] pri;
        logic signed [15:0] bottom;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] left;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic latch;   // capture the accepted word, restart the scan
        logic update;  // load or clear
        logic scan;    // step the scan
        logic emit;    // move results to the output register
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;

endpackage

FILE: rtl/prht_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module prht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/prht_ctrl.sv
// Controller for the hit table: sequences accept, update or scan, and output.
// Depends on prht_pkg.
module prht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  prht_pkg::t_op i_op,
    output logic          m_tvalid,
    input  logic          m_tready,
    output prht_pkg::t_cmd o_cmd,
    input  prht_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   w_accept;
    logic   w_emit;

    assign s_tready = (r_state == ST_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_emit   = (r_state == ST_DONE) && (!r_out_vld || m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == prht_pkg::OP_HIT || i_op == prht_pkg::OP_SET) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_emit) begin
            n_out_vld = 1'b1;
        end else if (m_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign m_tvalid      = r_out_vld;
    assign o_cmd.latch   = w_accept;
    assign o_cmd.update  = (r_state == ST_UPD);
    assign o_cmd.scan    = (r_state == ST_SCAN);
    assign o_cmd.emit    = w_emit;

endmodule

FILE: rtl/prht_dp.sv
// Datapath for the hit table: entry RAM, count, scan pipeline, result registers.
// Depends on prht_pkg and prht_ram.
module prht_dp #(
    parameter int MAX_ENTRIES = prht_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [prht_pkg::S_DATA_W-1:0] i_data,
    input  prht_pkg::t_op                 i_op,
    input  prht_pkg::t_cmd                i_cmd,
    output prht_pkg::t_sts                o_sts,
    output logic [prht_pkg::M_DATA_W-1:0] o_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    prht_pkg::t_item  r_item;
    prht_pkg::t_op    r_op;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_rd_idx;
    logic             r_pend;
    logic [AW-1:0]    r_pidx;
    logic             r_found;
    logic signed [31:0] r_best_pri;
    logic [prht_pkg::IDX_W-1:0] r_best_idx;
    logic             r_changed;
    logic [prht_pkg::M_DATA_W-1:0] r_odata;

    logic [prht_pkg::ENTRY_W-1:0] w_rd_data;
    prht_pkg::t_entry w_ent;
    prht_pkg::t_entry w_new;
    prht_pkg::t_entry w_upd;
    logic             w_idx_ok;
    logic             w_rd_en;
    logic             w_inside;
    logic             w_hit_take;
    logic             w_set_wr;
    logic             w_load_wr;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [prht_pkg::ENTRY_W-1:0] w_wdata;

    assign w_ent    = prht_pkg::t_entry'(w_rd_data);
    assign w_idx_ok = ({24'd0, r_item.idx} < 32'(MAX_ENTRIES));
    assign w_rd_en  = (r_rd_idx < r_count);

    assign w_inside = !($signed(r_item.px) < $signed(w_ent.left)  ||
                        $signed(r_item.px) > $signed(w_ent.right) ||
                        $signed(r_item.py) < $signed(w_ent.top)   ||
                        $signed(r_item.py) > $signed(w_ent.bottom));

    assign w_hit_take = r_pend && (r_op == prht_pkg::OP_HIT) && !w_ent.excl &&
                        (w_ent.dis == 8'd0) && w_inside &&
                        (!r_found || ($signed(w_ent.pri) > r_best_pri));

    assign w_set_wr = r_pend && (r_op == prht_pkg::OP_SET) &&
                      (w_ent.tag == r_item.tag) && (w_ent.dis != r_item.dis);

    assign w_load_wr = i_cmd.update && (r_op == prht_pkg::OP_LOAD) && w_idx_ok;

    always_comb begin
        w_new.excl   = r_item.excl;
        w_new.dis    = r_item.dis;
        w_new.tag    = r_item.tag;
        w_new.pri    = r_item.pri;
        w_new.bottom = r_item.bottom;
        w_new.right  = r_item.right;
        w_new.top    = r_item.top;
        w_new.left   = r_item.left;
        w_upd        = w_ent;
        w_upd.dis    = r_item.dis;
    end

    // set writes back entry r_pidx while the read port already fetches the next one
    assign w_we    = w_load_wr || w_set_wr;
    assign w_waddr = w_load_wr ? AW'(r_item.idx) : r_pidx;
    assign w_wdata = w_load_wr ? w_new : w_upd;

    prht_ram #(
        .WIDTH (prht_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= prht_pkg::t_item'(i_data);
            r_op   <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_changed <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                if (r_op == prht_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end else if (w_idx_ok) begin
                    r_count <= CW'(r_item.idx) + CW'(1);
                end
            end
            if (i_cmd.latch) begin
                r_rd_idx  <= '0;
                r_pend    <= 1'b0;
                r_found   <= 1'b0;
                r_changed <= 1'b0;
            end else begin
                r_pend <= i_cmd.scan && w_rd_en;
                if (i_cmd.scan && w_rd_en) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                if (w_hit_take) begin
                    r_found <= 1'b1;
                end
                if (w_set_wr) begin
                    r_changed <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_rd_idx[AW-1:0];
        if (i_cmd.latch) begin
            r_best_idx <= '0;
            r_best_pri <= '0;
        end else if (w_hit_take) begin
            r_best_idx <= prht_pkg::IDX_W'(r_pidx);
            r_best_pri <= $signed(w_ent.pri);
        end
        if (i_cmd.emit) begin
            r_odata <= {6'd0, r_changed, r_best_idx, r_found};
        end
    end

    assign o_sts.scan_done = !w_rd_en && !r_pend;
    assign o_data          = r_odata;

endmodule

FILE: rtl/priority_rect_hit_table_unit.sv
// Top level of the priority rectangle hit table.
// Depends on prht_pkg, prht_ctrl, prht_dp (which holds prht_ram).
//
// Use: one command word enters on the s_ channel; tuser carries the operation
// (load entry, hit test, set disable byte by tag, clear). Every command gives
// exactly one result word on the m_ channel.
// Load and clear pass from accept through an update state and a done state
// to the output register. Hit test and set-by-tag walk the table through the
// single entry RAM, one entry per cycle, with each read going through the
// RAM read register before it is compared, and then through the done state.
// One command in flight; s_tready rises in the cycle its result goes valid.
// The result sits in an output register, so a new command
// is taken while an earlier result still waits for m_tready; when the receiver
// stalls, a finished second result holds the block until the register frees.
// Reset clears the entry count and the handshake state; table contents are
// not cleared and only entries below the count are ever read.
// s_tdata: entry_index[7:0], box_left[23:8], box_top[39:24], box_right[55:40],
// box_bottom[71:56], disable_byte[79:72], region_tag[111:80],
// priority_req[143:112], excluded[144], point_x[160:145], point_y[176:161].
module priority_rect_hit_table_unit #(
    parameter int MAX_ENTRIES = prht_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index, box_left, box_top, box_right, box_bottom, disable_byte,
    // region_tag, priority_req, excluded, point_x, point_y (low bit up)
    input  logic [prht_pkg::S_DATA_W-1:0] s_tdata,
    // op
    input  logic [prht_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_found, hit_entry, any_changed (low bit up)
    output logic [prht_pkg::M_DATA_W-1:0] m_tdata
);

    prht_pkg::t_cmd w_cmd;
    prht_pkg::t_sts w_sts;
    prht_pkg::t_op  w_op;

    assign w_op = prht_pkg::t_op'(s_tuser);

    prht_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_op     (w_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .o_cmd    (w_cmd),
        .i_sts    (w_sts)
    );

    prht_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (s_tdata),
        .i_op    (w_op),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_data  (m_tdata)
    );

endmodule

FILE: tb/priority_rect_hit_table_unit_tb.sv
// Self-checking testbench for priority_rect_hit_table_unit: drives command words
// with random pacing, predicts every result word from its own copy of the table.
// Depends on prht_pkg and the RTL of the unit.
module priority_rect_hit_table_unit_tb;

    typedef struct {
        prht_pkg::t_op op;
        logic          found;
        logic [7:0]    entry;
        logic          changed;
    } t_answer;

    logic                          i_clk    = 1'b0;
    logic                          i_rst_n  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [prht_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [prht_pkg::S_USER_W-1:0] s_tuser  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [prht_pkg::M_DATA_W-1:0] m_tdata;

    // predictor state
    prht_pkg::t_entry tbl [prht_pkg::MAX_ENTRIES_DEF];
    int          tbl_count  = 0;
    int          tbl_filled = 0;  // entries 0..tbl_filled-1 written since reset/clear
    t_answer     answer_q[$];

    int          mismatch_cnt  = 0;
    int          result_cnt    = 0;
    bit          src_steady    = 1'b0;
    bit          sink_steady   = 1'b0;
    bit          sink_hold_req = 1'b0;

    priority_rect_hit_table_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int rng(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_answer table_answer(prht_pkg::t_op op, prht_pkg::t_item it);
        t_answer            a;
        prht_pkg::t_entry   e;
        logic signed [31:0] best;
        int                 i;
        a = '{op: op, found: 1'b0, entry: 8'd0, changed: 1'b0};
        best = '0;
        case (op)
            prht_pkg::OP_LOAD: begin
                e.left   = it.left;
                e.top    = it.top;
                e.right  = it.right;
                e.bottom = it.bottom;
                e.pri    = it.pri;
                e.tag    = it.tag;
                e.dis    = it.dis;
                e.excl   = it.excl;
                tbl[it.idx] = e;
                tbl_count = int'(it.idx) + 1;
                if (int'(it.idx) == tbl_filled) tbl_filled++;
            end
            prht_pkg::OP_HIT: begin
                for (i = 0; i < tbl_count; i++) begin
                    e = tbl[i];
                    if (e.excl || e.dis != 8'd0) continue;
                    if ($signed(it.px) < $signed(e.left) || $signed(it.px) > $signed(e.right) ||
                        $signed(it.py) < $signed(e.top) || $signed(it.py) > $signed(e.bottom))
                        continue;
                    // strictly greater: earliest entry keeps a tie
                    if (!a.found || $signed(e.pri) > best) begin
                        a.found = 1'b1;
                        a.entry = 8'(i);
                        best    = e.pri;
                    end
                end
            end
            prht_pkg::OP_SET: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl[i].tag == it.tag && tbl[i].dis != it.dis) begin
                        tbl[i].dis = it.dis;
                        a.changed  = 1'b1;
                    end
                end
            end
            default: begin
                tbl_count  = 0;
                tbl_filled = 0;
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // one word on the slave side; predicts its answer at the accepting edge
    task automatic send_word(prht_pkg::t_op op, prht_pkg::t_item it);
        int unsigned gap;
        t_answer     ans;
        gap = src_steady ? 0 : $urandom_range(0, 15);
        s_tdata  <= it;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        ans = table_answer(op, it);
        answer_q = {answer_q, ans};
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic prht_pkg::t_item blank_word();
        prht_pkg::t_item it;
        it.pad    = '0;
        it.idx    = 8'($urandom);
        it.left   = 16'($urandom);
        it.top    = 16'($urandom);
        it.right  = 16'($urandom);
        it.bottom = 16'($urandom);
        it.dis    = 8'($urandom);
        it.tag    = $urandom;
        it.pri    = $urandom;
        it.excl   = 1'($urandom);
        it.px     = 16'($urandom);
        it.py     = 16'($urandom);
        return it;
    endfunction

    function automatic prht_pkg::t_item entry_word(int idx, int l, int t, int r, int b,
                                                   logic [31:0] pri, logic [31:0] tag,
                                                   logic [7:0] dis, logic excl);
        prht_pkg::t_item it;
        it = blank_word();
        it.idx    = 8'(idx);
        it.left   = 16'(l);
        it.top    = 16'(t);
        it.right  = 16'(r);
        it.bottom = 16'(b);
        it.pri    = pri;
        it.tag    = tag;
        it.dis    = dis;
        it.excl   = excl;
        return it;
    endfunction

    function automatic prht_pkg::t_item point_word(int x, int y);
        prht_pkg::t_item it;
        it = blank_word();
        it.px = 16'(x);
        it.py = 16'(y);
        return it;
    endfunction

    function automatic prht_pkg::t_item tag_word(logic [31:0] tag, logic [7:0] dis);
        prht_pkg::t_item it;
        it = blank_word();
        it.tag = tag;
        it.dis = dis;
        return it;
    endfunction

    function automatic prht_pkg::t_op pick_op();
        int r;
        r = rng(0, 99);
        if (r < 35) return prht_pkg::OP_LOAD;
        if (r < 75) return prht_pkg::OP_HIT;
        if (r < 96) return prht_pkg::OP_SET;
        return prht_pkg::OP_CLEAR;
    endfunction

    // random word; loads never leave an unwritten entry below the count
    function automatic prht_pkg::t_item random_word(prht_pkg::t_op op, int cap);
        prht_pkg::t_item it;
        int              l, t, top_idx;
        it = blank_word();
        case (op)
            prht_pkg::OP_LOAD: begin
                top_idx = (tbl_filled < cap) ? tbl_filled : cap - 1;
                it.idx  = 8'(rng(0, 1) == 0 ? top_idx : rng(0, top_idx));
                if (rng(0, 9) != 0) begin
                    l = rng(-40, 40);
                    t = rng(-40, 40);
                    it.left   = 16'(l);
                    it.top    = 16'(t);
                    it.right  = 16'(l + rng(-4, 40));
                    it.bottom = 16'(t + rng(-4, 40));
                end
                if (rng(0, 19) < 17) it.pri = 32'(rng(-3, 4));
                if (rng(0, 19) < 17) it.tag = 32'(rng(0, 5));
                if (rng(0, 3) != 0)  it.dis = 8'd0;
                it.excl = (rng(0, 19) < 3);
            end
            prht_pkg::OP_HIT: begin
                if (rng(0, 19) < 17) begin
                    it.px = 16'(rng(-48, 90));
                    it.py = 16'(rng(-48, 90));
                end
            end
            prht_pkg::OP_SET: begin
                if (rng(0, 19) < 17) it.tag = 32'(rng(0, 5));
                if (rng(0, 1) == 0)  it.dis = 8'd0;
            end
            default: ;
        endcase
        return it;
    endfunction

    // result side pacing; a hold request stalls the master side for a long stretch
    initial begin : sink_pacing
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                stall_left = 400;
            end else if (m_tvalid && m_tready) begin
                stall_left = sink_steady ? 0 : $urandom_range(0, 15);
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // m_tdata: hit_found[0], hit_entry[8:1], any_changed[9]
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                report_mismatch($sformatf("result word %0d with none pending: %h",
                                          result_cnt, m_tdata));
            end else begin
                exp_a = answer_q.pop_front();
                if (m_tdata[0] !== exp_a.found)
                    report_mismatch($sformatf("%s word %0d: hit_found %b, want %b",
                                              exp_a.op.name(), result_cnt, m_tdata[0],
                                              exp_a.found));
                if (m_tdata[8:1] !== exp_a.entry)
                    report_mismatch($sformatf("%s word %0d: hit_entry %0d, want %0d",
                                              exp_a.op.name(), result_cnt, m_tdata[8:1],
                                              exp_a.entry));
                if (m_tdata[9] !== exp_a.changed)
                    report_mismatch($sformatf("%s word %0d: any_changed %b, want %b",
                                              exp_a.op.name(), result_cnt, m_tdata[9],
                                              exp_a.changed));
            end
            result_cnt++;
        end
    end

    task automatic test_directed();
        send_word(prht_pkg::OP_HIT, point_word(0, 0));               // empty table
        send_word(prht_pkg::OP_SET, tag_word(32'd0, 8'd1));
        send_word(prht_pkg::OP_LOAD, entry_word(0, -32768, -32768, 32767, 32767,
                                                32'h8000_0000, 32'hFFFF_FFFF, 8'd0, 1'b0));
        send_word(prht_pkg::OP_LOAD, entry_word(1, 10, 10, 20, 20, 32'd100, 32'd1,
                                                8'd0, 1'b0));
        send_word(prht_pkg::OP_LOAD, entry_word(2, 10, 10, 20, 20, 32'd100, 32'd2,
                                                8'd0, 1'b0));
        send_word(prht_pkg::OP_LOAD, entry_word(3, -32768, -32768, 32767, 32767,
                                                32'h7FFF_FFFF, 32'd3, 8'd0, 1'b1));
        send_word(prht_pkg::OP_LOAD, entry_word(4, -32768, -32768, 32767, 32767,
                                                32'h7FFF_FFFF, 32'd4, 8'hFF, 1'b0));
        // left above right: never contains a point
        send_word(prht_pkg::OP_LOAD, entry_word(5, 30, 0, -30, 100, 32'h7FFF_FFFF, 32'd5,
                                                8'd0, 1'b0));
        send_word(prht_pkg::OP_LOAD, entry_word(6, 20, 20, 40, 40, 32'd101, 32'h8000_0000,
                                                8'd0, 1'b0));
        send_word(prht_pkg::OP_HIT, point_word(15, 15));             // tie, earliest wins
        send_word(prht_pkg::OP_HIT, point_word(20, 20));             // inclusive corner
        send_word(prht_pkg::OP_HIT, point_word(21, 19));
        send_word(prht_pkg::OP_HIT, point_word(-32768, -32768));
        send_word(prht_pkg::OP_HIT, point_word(32767, 32767));
        send_word(prht_pkg::OP_SET, tag_word(32'd4, 8'd0));
        send_word(prht_pkg::OP_SET, tag_word(32'd4, 8'd0));          // same byte, no change
        send_word(prht_pkg::OP_HIT, point_word(15, 15));
        send_word(prht_pkg::OP_SET, tag_word(32'd9, 8'd7));
        send_word(prht_pkg::OP_LOAD, entry_word(2, 10, 10, 20, 20, 32'd100, 32'd2,
                                                8'd0, 1'b0));
        send_word(prht_pkg::OP_HIT, point_word(15, 15));
        send_word(prht_pkg::OP_SET, tag_word(32'd4, 8'd5));          // entry above the count
        send_word(prht_pkg::OP_LOAD, entry_word(6, 20, 20, 40, 40, 32'd101, 32'h8000_0000,
                                                8'd0, 1'b0));
        send_word(prht_pkg::OP_HIT, point_word(-1, -1));
        send_word(prht_pkg::OP_CLEAR, blank_word());
        send_word(prht_pkg::OP_HIT, point_word(15, 15));
    endtask

    task automatic test_random_ops(int n_items);
        int            cap;
        int            i;
        prht_pkg::t_op op;
        cap = 8;
        for (i = 0; i < n_items; i++) begin
            if (i % 100 == 0) begin
                cap         = rng(1, 24);
                src_steady  = (rng(0, 3) == 0);
                sink_steady = (rng(0, 3) == 0);
            end
            op = pick_op();
            send_word(op, random_word(op, cap));
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // master side stalls for a long stretch while words keep coming
    task automatic test_output_stall();
        int            i;
        prht_pkg::t_op op;
        src_steady    = 1'b1;
        sink_hold_req = 1'b1;
        for (i = 0; i < 40; i++) begin
            op = pick_op();
            send_word(op, random_word(op, 8));
        end
        src_steady = 1'b0;
    endtask

    task automatic test_full_table();
        int              i;
        prht_pkg::t_op   op;
        prht_pkg::t_item it;
        send_word(prht_pkg::OP_CLEAR, blank_word());
        for (i = 0; i < prht_pkg::MAX_ENTRIES_DEF; i++) begin
            it = random_word(prht_pkg::OP_LOAD, prht_pkg::MAX_ENTRIES_DEF);
            it.idx = 8'(i);
            send_word(prht_pkg::OP_LOAD, it);
        end
        for (i = 0; i < 80; i++) begin
            op = pick_op();
            if (op == prht_pkg::OP_CLEAR) op = prht_pkg::OP_HIT;
            send_word(op, random_word(op, prht_pkg::MAX_ENTRIES_DEF));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_ops(700);
        test_output_stall();
        test_full_table();
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_cnt == 0 && answer_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
